// File: hdl/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared constants and the result record of the biconnected component finder.
// ----------------------------------------------------------------------------
package bcf_pkg;

    // Default sizes handed to the top level
    localparam int MAX_VERTICES_DEF     = 64;
    localparam int EDGE_STACK_DEPTH_DEF = 2048;

    // Transaction modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_FETCH  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // One result transaction
    typedef struct packed {
        logic        edge_valid;
        logic [6:0]  first_vertex;
        logic [6:0]  second_vertex;
        logic [6:0]  first_label;
        logic [6:0]  second_label;
        logic [10:0] component_number;
        logic        component_end;
        logic [6:0]  component_vertices;
        logic        all_done;
    } t_result;

endpackage

// File: hdl/biconnected_component_finder.sv
// ----------------------------------------------------------------------------
// biconnected_component_finder
// Graph loader and biconnected component enumerator with a command interface.
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low. Clear and
// ignored modes finish in the accepting cycle; an append with a valid owner
// passes through ST_APP. A fetch runs the depth-first search until the next
// edge pops or the search ends. After ST_ADV, a skipped adjacency entry takes
// ST_ADJ, a back edge ST_ADJ and ST_W, a tree edge ST_ADJ, ST_W and ST_VIS, a
// vertex left ST_PF and ST_PV, a new root ST_ROOT; a root left and a visited
// vertex passed over by the root cursor take nothing more. A popped edge
// passes ST_POP, ST_EDGE, ST_LU and ST_LV to its result, so the length of a
// fetch depends on the graph. The per-vertex record memory, read one entry
// per cycle, sets that pace. Each fetch produces exactly one result, shown
// for one cycle with o_strobe; there is no back-pressure, so the receiver
// must take it then. The user must write the vertex count register with
// i_cfg_we only while the block is idle (not enforced), restarting the search.
// ----------------------------------------------------------------------------
module biconnected_component_finder
    import bcf_pkg::*;
#(
    parameter int MAX_VERTICES     = MAX_VERTICES_DEF,
    parameter int EDGE_STACK_DEPTH = EDGE_STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_owner_vertex,
    input  logic [6:0]  i_neighbour_vertex,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic        o_edge_valid,
    output logic [6:0]  o_first_vertex,
    output logic [6:0]  o_second_vertex,
    output logic [6:0]  o_first_label,
    output logic [6:0]  o_second_label,
    output logic [10:0] o_component_number,
    output logic        o_component_end,
    output logic [6:0]  o_component_vertices,
    output logic        o_all_done
);

    logic [6:0] r_vcount;
    t_result    res;

    // Hold the vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    bcf_engine #(
        .MAX_VERTICES     (MAX_VERTICES),
        .EDGE_STACK_DEPTH (EDGE_STACK_DEPTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_mode    (i_mode),
        .i_owner   (i_owner_vertex),
        .i_nb      (i_neighbour_vertex),
        .i_cfg_we  (i_cfg_we),
        .i_vcount  (r_vcount),
        .o_busy    (o_busy),
        .o_res_vld (o_strobe),
        .o_res     (res)
    );

    // Unpack the result record
    assign o_edge_valid         = res.edge_valid;
    assign o_first_vertex       = res.first_vertex;
    assign o_second_vertex      = res.second_vertex;
    assign o_first_label        = res.first_label;
    assign o_second_label       = res.second_label;
    assign o_component_number   = res.component_number;
    assign o_component_end      = res.component_end;
    assign o_component_vertices = res.component_vertices;
    assign o_all_done           = res.all_done;

endmodule

// File: hdl/bcf_engine.sv
// ----------------------------------------------------------------------------
// bcf_engine
// Depth-first search engine over four simple dual-port synchronous memories:
// adjacency lists, per-vertex records, search frames and the edge stack.
// ----------------------------------------------------------------------------
module bcf_engine
    import bcf_pkg::*;
#(
    parameter int MAX_VERTICES     = MAX_VERTICES_DEF,
    parameter int EDGE_STACK_DEPTH = EDGE_STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_owner,
    input  logic [6:0] i_nb,
    input  logic       i_cfg_we,
    input  logic [6:0] i_vcount,
    output logic       o_busy,
    output logic       o_res_vld,
    output t_result    o_res
);

    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int NV = MAX_VERTICES + 1;
    localparam int FW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AD = NV * MAX_VERTICES;
    localparam int AW = $clog2(AD);
    localparam int EW = $clog2(EDGE_STACK_DEPTH);
    localparam int TW = $clog2(EDGE_STACK_DEPTH + 1);

    typedef struct packed {
        logic [VW-1:0] disc;
        logic [VW-1:0] low;
        logic [VW-1:0] par;
        logic [VW-1:0] deg;
        logic [VW-1:0] lab;
    } t_vword;

    typedef enum logic [3:0] {
        ST_IDLE, ST_APP, ST_ADV, ST_ROOT, ST_ADJ, ST_W, ST_VIS,
        ST_PF, ST_PV, ST_POP, ST_EDGE, ST_LU, ST_LV
    } t_state;

    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_POP, PH_DONE} t_phase;

    // Memories and their ports
    logic [6:0]      adj_mem [AD];
    t_vword          v_mem   [NV];
    logic [2*VW-1:0] f_mem   [MAX_VERTICES];
    logic [2*VW-1:0] e_mem   [EDGE_STACK_DEPTH];

    logic            a_we, a_re;
    logic [AW-1:0]   a_waddr, a_raddr;
    logic [6:0]      r_ard;
    logic            v_we, v_re;
    logic [VW-1:0]   v_waddr, v_raddr;
    t_vword          v_wdata, r_vrd;
    logic            f_we, f_re;
    logic [FW-1:0]   f_waddr, f_raddr;
    logic [2*VW-1:0] f_wdata, r_frd;
    logic            e_we, e_re;
    logic [EW-1:0]   e_waddr, e_raddr;
    logic [2*VW-1:0] e_wdata, r_erd;

    // Control state
    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [NV-1:0]   r_deg_vld, n_deg_vld;
    logic [NV-1:0]   r_vis, n_vis;
    logic [NV-1:0]   r_lab_vld, n_lab_vld;
    logic [VW-1:0]   r_depth, n_depth;
    logic [TW-1:0]   r_top, n_top;
    logic [VW:0]     r_dc, n_dc;
    logic [VW:0]     r_root, n_root;
    logic [10:0]     r_comp, n_comp;
    logic [VW-1:0]   r_lab_cnt, n_lab_cnt;
    logic            r_res_vld, n_res_vld;
    t_result         r_res, n_res;

    // Payload registers
    logic [6:0]      r_owner, n_owner;
    logic [6:0]      r_nb, n_nb;
    logic [6:0]      r_w, n_w;
    logic [VW-1:0]   r_p, n_p;
    logic [VW-1:0]   r_u, n_u;
    logic [VW-1:0]   r_ev, n_ev;
    logic [VW-1:0]   r_lu, n_lu;
    logic [VW-1:0]   r_goal_f, n_goal_f;
    logic [VW-1:0]   r_goal_s, n_goal_s;
    logic [VW-1:0]   r_t_v, n_t_v;
    logic [VW-1:0]   r_t_scan, n_t_scan;
    logic [VW-1:0]   r_t_deg, n_t_deg;
    logic [VW-1:0]   r_t_disc, n_t_disc;
    logic [VW-1:0]   r_t_low, n_t_low;
    logic [VW-1:0]   r_t_par, n_t_par;
    logic [VW-1:0]   r_t_lab, n_t_lab;

    logic [VW-1:0]   n_eff;
    logic [VW-1:0]   deg_eff;
    logic [VW-1:0]   wi;
    logic [VW-1:0]   lab_new;
    logic            comp_end;

    assign n_eff = (int'(i_vcount) < MAX_VERTICES) ? VW'(i_vcount) : VW'(MAX_VERTICES);
    assign wi    = VW'(r_w);

    // Next-state and memory port logic
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_deg_vld = r_deg_vld;
        n_vis     = r_vis;
        n_lab_vld = r_lab_vld;
        n_depth   = r_depth;
        n_top     = r_top;
        n_dc      = r_dc;
        n_root    = r_root;
        n_comp    = r_comp;
        n_lab_cnt = r_lab_cnt;
        n_res_vld = 1'b0;
        n_res     = r_res;
        n_owner   = r_owner;
        n_nb      = r_nb;
        n_w       = r_w;
        n_p       = r_p;
        n_u       = r_u;
        n_ev      = r_ev;
        n_lu      = r_lu;
        n_goal_f  = r_goal_f;
        n_goal_s  = r_goal_s;
        n_t_v     = r_t_v;
        n_t_scan  = r_t_scan;
        n_t_deg   = r_t_deg;
        n_t_disc  = r_t_disc;
        n_t_low   = r_t_low;
        n_t_par   = r_t_par;
        n_t_lab   = r_t_lab;
        a_we = 1'b0; a_re = 1'b0; a_waddr = '0; a_raddr = '0;
        v_we = 1'b0; v_re = 1'b0; v_waddr = '0; v_raddr = '0; v_wdata = r_vrd;
        f_we = 1'b0; f_re = 1'b0; f_waddr = '0; f_raddr = '0; f_wdata = '0;
        e_we = 1'b0; e_re = 1'b0; e_waddr = '0; e_raddr = '0; e_wdata = '0;
        deg_eff  = '0;
        lab_new  = '0;
        comp_end = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_phase = PH_IDLE;
                end
                if (i_start) begin
                    n_owner = i_owner;
                    n_nb    = i_nb;
                    unique case (i_mode)
                        MODE_CLEAR: begin
                            n_deg_vld = '0;
                            n_phase   = PH_IDLE;
                        end
                        MODE_APPEND: begin
                            n_phase = PH_IDLE;
                            if (i_owner != 7'd0 && int'(i_owner) <= MAX_VERTICES) begin
                                v_re    = 1'b1;
                                v_raddr = VW'(i_owner);
                                n_state = ST_APP;
                            end
                        end
                        MODE_FETCH: begin
                            unique case (r_phase)
                                PH_IDLE: begin
                                    n_vis     = '0;
                                    n_depth   = '0;
                                    n_top     = '0;
                                    n_lab_cnt = '0;
                                    n_dc      = (VW+1)'(1);
                                    n_root    = (VW+1)'(1);
                                    n_comp    = '0;
                                    n_phase   = PH_RUN;
                                    n_state   = ST_ADV;
                                end
                                PH_RUN:  n_state = ST_ADV;
                                PH_POP:  n_state = ST_POP;
                                default: begin
                                    n_res          = '0;
                                    n_res.all_done = 1'b1;
                                    n_res_vld      = 1'b1;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end

            // Append at the end of the owner's list
            ST_APP: begin
                deg_eff = r_deg_vld[VW'(r_owner)] ? r_vrd.deg : '0;
                if (int'(deg_eff) < MAX_VERTICES) begin
                    a_we    = 1'b1;
                    a_waddr = AW'(int'(VW'(r_owner)) * MAX_VERTICES + int'(deg_eff));
                    v_we    = 1'b1;
                    v_waddr = VW'(r_owner);
                    v_wdata = r_vrd;
                    v_wdata.deg = deg_eff + VW'(1);
                    n_deg_vld[VW'(r_owner)] = 1'b1;
                end
                n_state = ST_IDLE;
            end

            // Dispatch one search step
            ST_ADV: begin
                if (r_depth == '0) begin
                    if (r_root > {1'b0, n_eff}) begin
                        n_phase        = PH_DONE;
                        n_res          = '0;
                        n_res.all_done = 1'b1;
                        n_res_vld      = 1'b1;
                        n_state        = ST_IDLE;
                    end else if (r_vis[r_root[VW-1:0]]) begin
                        n_root = r_root + (VW+1)'(1);
                    end else begin
                        v_re    = 1'b1;
                        v_raddr = r_root[VW-1:0];
                        n_state = ST_ROOT;
                    end
                end else if (r_t_scan < r_t_deg) begin
                    a_re     = 1'b1;
                    a_raddr  = AW'(int'(r_t_v) * MAX_VERTICES + int'(r_t_scan));
                    n_t_scan = r_t_scan + VW'(1);
                    n_state  = ST_ADJ;
                end else begin
                    n_depth = r_depth - VW'(1);
                    if (r_depth != VW'(1)) begin
                        f_re    = 1'b1;
                        f_raddr = FW'(r_depth - VW'(2));
                        n_state = ST_PF;
                    end
                end
            end

            // Open a new tree at the root cursor
            ST_ROOT: begin
                deg_eff   = r_deg_vld[r_root[VW-1:0]] ? r_vrd.deg : '0;
                n_vis[r_root[VW-1:0]] = 1'b1;
                v_we      = 1'b1;
                v_waddr   = r_root[VW-1:0];
                v_wdata   = '{disc: VW'(r_dc), low: VW'(r_dc), par: '0,
                              deg: deg_eff, lab: r_vrd.lab};
                n_t_v     = r_root[VW-1:0];
                n_t_scan  = '0;
                n_t_deg   = deg_eff;
                n_t_disc  = VW'(r_dc);
                n_t_low   = VW'(r_dc);
                n_t_par   = '0;
                n_t_lab   = r_vrd.lab;
                n_dc      = r_dc + (VW+1)'(1);
                n_depth   = VW'(1);
                n_state   = ST_ADV;
            end

            // Filter the neighbour entry
            ST_ADJ: begin
                n_w = r_ard;
                if (r_ard == 7'd0 || int'(r_ard) > int'(n_eff)) begin
                    n_state = ST_ADV;
                end else begin
                    v_re    = 1'b1;
                    v_raddr = VW'(r_ard);
                    n_state = ST_W;
                end
            end

            // Back edge or tree edge
            ST_W: begin
                n_state = ST_ADV;
                if (r_vis[wi]) begin
                    if (r_t_par != wi && r_vrd.disc < r_t_disc) begin
                        if (int'(r_top) < EDGE_STACK_DEPTH) begin
                            e_we    = 1'b1;
                            e_waddr = r_top[EW-1:0];
                            e_wdata = {r_t_v, wi};
                            n_top   = r_top + TW'(1);
                        end
                        if (r_vrd.disc < r_t_low) begin
                            n_t_low = r_vrd.disc;
                        end
                    end
                end else begin
                    if (int'(r_top) < EDGE_STACK_DEPTH) begin
                        e_we    = 1'b1;
                        e_waddr = r_top[EW-1:0];
                        e_wdata = {r_t_v, wi};
                        n_top   = r_top + TW'(1);
                    end
                    v_we     = 1'b1;
                    v_waddr  = r_t_v;
                    v_wdata  = '{disc: r_t_disc, low: r_t_low, par: r_t_par,
                                 deg: r_t_deg, lab: r_t_lab};
                    f_we     = 1'b1;
                    f_waddr  = FW'(r_depth - VW'(1));
                    f_wdata  = {r_t_v, r_t_scan};
                    n_t_v    = wi;
                    n_t_par  = r_t_v;
                    n_t_disc = VW'(r_dc);
                    n_t_low  = VW'(r_dc);
                    n_t_scan = '0;
                    n_t_deg  = r_deg_vld[wi] ? r_vrd.deg : '0;
                    n_t_lab  = r_vrd.lab;
                    n_dc     = r_dc + (VW+1)'(1);
                    n_depth  = r_depth + VW'(1);
                    n_vis[wi] = 1'b1;
                    n_state  = ST_VIS;
                end
            end

            // Store the new vertex record
            ST_VIS: begin
                v_we    = 1'b1;
                v_waddr = r_t_v;
                v_wdata = '{disc: r_t_disc, low: r_t_low, par: r_t_par,
                            deg: r_t_deg, lab: r_t_lab};
                n_state = ST_ADV;
            end

            // Fetch the parent frame
            ST_PF: begin
                n_p      = r_frd[2*VW-1:VW];
                n_t_scan = r_frd[VW-1:0];
                v_re     = 1'b1;
                v_raddr  = r_frd[2*VW-1:VW];
                n_state  = ST_PV;
            end

            // Fold the child's low value and test for an articulation
            ST_PV: begin
                n_t_v    = r_p;
                n_t_disc = r_vrd.disc;
                n_t_low  = (r_t_low < r_vrd.low) ? r_t_low : r_vrd.low;
                n_t_par  = r_vrd.par;
                n_t_deg  = r_vrd.deg;
                n_t_lab  = r_vrd.lab;
                if (r_t_low >= r_vrd.disc && r_top != '0) begin
                    n_goal_f  = r_p;
                    n_goal_s  = r_t_v;
                    n_lab_vld = '0;
                    n_lab_cnt = '0;
                    n_phase   = PH_POP;
                    n_state   = ST_POP;
                end else begin
                    n_state = ST_ADV;
                end
            end

            // Pop one edge
            ST_POP: begin
                n_top   = r_top - TW'(1);
                e_re    = 1'b1;
                e_raddr = EW'(r_top - TW'(1));
                n_state = ST_EDGE;
            end

            ST_EDGE: begin
                n_u     = r_erd[2*VW-1:VW];
                n_ev    = r_erd[VW-1:0];
                v_re    = 1'b1;
                v_raddr = r_erd[2*VW-1:VW];
                n_state = ST_LU;
            end

            // Label the first endpoint, read the second
            ST_LU: begin
                if (r_lab_vld[r_u]) begin
                    n_lu = r_vrd.lab;
                end else begin
                    lab_new   = r_lab_cnt + VW'(1);
                    n_lu      = lab_new;
                    n_lab_cnt = lab_new;
                    n_lab_vld[r_u] = 1'b1;
                    v_we      = 1'b1;
                    v_waddr   = r_u;
                    v_wdata   = r_vrd;
                    v_wdata.lab = lab_new;
                end
                v_re    = 1'b1;
                v_raddr = r_ev;
                n_state = ST_LV;
            end

            // Label the second endpoint and emit
            ST_LV: begin
                n_res = '0;
                if (r_lab_vld[r_ev]) begin
                    n_res.second_label = 7'(r_vrd.lab);
                end else begin
                    lab_new   = r_lab_cnt + VW'(1);
                    n_lab_cnt = lab_new;
                    n_lab_vld[r_ev] = 1'b1;
                    v_we      = 1'b1;
                    v_waddr   = r_ev;
                    v_wdata   = r_vrd;
                    v_wdata.lab = lab_new;
                    n_res.second_label = 7'(lab_new);
                end
                comp_end = (r_u == r_goal_f && r_ev == r_goal_s) || r_top == '0;
                n_res.edge_valid         = 1'b1;
                n_res.first_vertex       = 7'(r_u);
                n_res.second_vertex      = 7'(r_ev);
                n_res.first_label        = 7'(r_lu);
                n_res.component_number   = r_comp;
                n_res.component_end      = comp_end;
                n_res.component_vertices = comp_end ? 7'(n_lab_cnt) : 7'd0;
                n_res_vld = 1'b1;
                if (comp_end) begin
                    n_comp  = r_comp + 11'd1;
                    n_phase = PH_RUN;
                end
                n_state = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (a_we) adj_mem[a_waddr] <= n_nb;
        if (a_re) r_ard <= adj_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) v_mem[v_waddr] <= v_wdata;
        if (v_re) r_vrd <= v_mem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) f_mem[f_waddr] <= f_wdata;
        if (f_re) r_frd <= f_mem[f_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (e_we) e_mem[e_waddr] <= e_wdata;
        if (e_re) r_erd <= e_mem[e_raddr];
    end

    // State machine and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_IDLE;
            r_deg_vld <= '0;
            r_vis     <= '0;
            r_lab_vld <= '0;
            r_depth   <= '0;
            r_top     <= '0;
            r_dc      <= (VW+1)'(1);
            r_root    <= (VW+1)'(1);
            r_comp    <= '0;
            r_lab_cnt <= '0;
            r_res_vld <= 1'b0;
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_deg_vld <= n_deg_vld;
            r_vis     <= n_vis;
            r_lab_vld <= n_lab_vld;
            r_depth   <= n_depth;
            r_top     <= n_top;
            r_dc      <= n_dc;
            r_root    <= n_root;
            r_comp    <= n_comp;
            r_lab_cnt <= n_lab_cnt;
            r_res_vld <= n_res_vld;
            r_res     <= n_res;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_owner  <= n_owner;
        r_nb     <= n_nb;
        r_w      <= n_w;
        r_p      <= n_p;
        r_u      <= n_u;
        r_ev     <= n_ev;
        r_lu     <= n_lu;
        r_goal_f <= n_goal_f;
        r_goal_s <= n_goal_s;
        r_t_v    <= n_t_v;
        r_t_scan <= n_t_scan;
        r_t_deg  <= n_t_deg;
        r_t_disc <= n_t_disc;
        r_t_low  <= n_t_low;
        r_t_par  <= n_t_par;
        r_t_lab  <= n_t_lab;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    // Checks
    ap_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_top) <= EDGE_STACK_DEPTH)
        else $error("edge stack pointer past its depth");

    ap_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= MAX_VERTICES)
        else $error("search depth past vertex limit");

    ap_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> (r_top != '0))
        else $error("pop from empty edge stack");

    ap_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.edge_valid) |-> !r_res.all_done)
        else $error("edge result flagged as finished");

    ap_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_mode == MODE_CLEAR) |=> (r_state == ST_IDLE))
        else $error("clear left the engine busy");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the biconnected component finder: loads random
// graphs, fetches component edges and compares each result with a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import bcf_pkg::*;

    localparam int NV    = MAX_VERTICES_DEF;
    localparam int ESD   = EDGE_STACK_DEPTH_DEF;
    localparam int LIMIT = 4000000;

    // Search phases of the predictor
    typedef enum int {SP_IDLE, SP_RUN, SP_POP, SP_DONE} t_search_phase;

    // ------------------------------------------------------------------------
    // Scoreboard: graph and search predictor plus queue of pending results
    // ------------------------------------------------------------------------
    class bcf_scoreboard;
        int            n_vert;
        int            adj[NV+1][NV];
        int            deg[NV+1];
        bit            seen[NV+1];
        int            disc[NV+1];
        int            low[NV+1];
        int            par[NV+1];
        int            fr_v[NV];
        int            fr_scan[NV];
        int            depth;
        int            es_a[ESD];
        int            es_b[ESD];
        int            es_top;
        int            lbl[NV+1];
        int            lbl_cnt;
        int            disc_cnt;
        int            root;
        int            comp_cnt;
        t_search_phase phase;
        int            goal_a;
        int            goal_b;
        int            errors;
        t_result       pending_results[$];

        function new();
            n_vert = 0;
            foreach (deg[i]) deg[i] = 0;
            foreach (lbl[i]) lbl[i] = 0;
            restart();
            phase = SP_IDLE;
            errors = 0;
        endfunction

        function void restart();
            foreach (seen[i]) seen[i] = 0;
            depth = 0; es_top = 0; lbl_cnt = 0; disc_cnt = 1; root = 1;
            comp_cnt = 0; phase = SP_RUN;
        endfunction

        function void set_count(int val);
            n_vert = val;
            phase = SP_IDLE;
        endfunction

        function void push_pair(int a, int b);
            if (es_top < ESD) begin
                es_a[es_top] = a; es_b[es_top] = b; es_top++;
            end
        endfunction

        function void enter(int w);
            seen[w] = 1; disc[w] = disc_cnt; low[w] = disc_cnt; disc_cnt++;
            if (depth < NV) begin
                fr_v[depth] = w; fr_scan[depth] = 0; depth++;
            end
        endfunction

        // Run the search until a component is ready to pop or the search is done
        function bit walk();
            int n, v, w, p;
            n = (n_vert < NV) ? n_vert : NV;
            forever begin
                if (depth == 0) begin
                    while (root <= n && seen[root]) root++;
                    if (root > n) return 0;
                    par[root] = 0;
                    enter(root);
                    continue;
                end
                v = fr_v[depth-1];
                if (fr_scan[depth-1] < deg[v]) begin
                    w = adj[v][fr_scan[depth-1]];
                    fr_scan[depth-1]++;
                    if (w == 0 || w > n) continue;
                    if (seen[w]) begin
                        if (par[v] != w && disc[w] < disc[v]) begin
                            push_pair(v, w);
                            if (disc[w] < low[v]) low[v] = disc[w];
                        end
                    end else begin
                        push_pair(v, w);
                        par[w] = v;
                        enter(w);
                    end
                end else begin
                    depth--;
                    if (depth == 0) continue;
                    p = fr_v[depth-1];
                    if (low[v] < low[p]) low[p] = low[v];
                    if (low[v] >= disc[p] && es_top > 0) begin
                        goal_a = p; goal_b = v;
                        foreach (lbl[i]) lbl[i] = 0;
                        lbl_cnt = 0;
                        return 1;
                    end
                end
            end
        endfunction

        function int label_for(int x);
            if (x > NV) return 0;
            if (lbl[x] == 0) begin
                lbl_cnt++; lbl[x] = lbl_cnt;
            end
            return lbl[x];
        endfunction

        // Note one accepted command transaction
        function void note_command(logic [1:0] mode, logic [6:0] owner, logic [6:0] nb);
            t_result r;
            int a, b;
            bit last;
            r = '0;
            if (mode == MODE_CLEAR) begin
                foreach (deg[i]) deg[i] = 0;
                phase = SP_IDLE;
            end else if (mode == MODE_APPEND) begin
                if (owner >= 1 && owner <= NV && deg[owner] < NV) begin
                    adj[owner][deg[owner]] = int'(nb); deg[owner]++;
                end
                phase = SP_IDLE;
            end else if (mode == MODE_FETCH) begin
                if (phase == SP_IDLE) restart();
                if (phase == SP_RUN) phase = walk() ? SP_POP : SP_DONE;
                if (phase != SP_POP) begin
                    r.all_done = 1'b1;
                end else begin
                    es_top--;
                    a = es_a[es_top]; b = es_b[es_top];
                    r.edge_valid = 1'b1;
                    r.first_vertex = 7'(a);
                    r.second_vertex = 7'(b);
                    r.first_label = 7'(label_for(a));
                    r.second_label = 7'(label_for(b));
                    r.component_number = 11'(comp_cnt);
                    last = (a == goal_a && b == goal_b) || es_top == 0;
                    r.component_end = last;
                    r.component_vertices = last ? 7'(lbl_cnt) : 7'd0;
                    if (last) begin
                        comp_cnt = (comp_cnt + 1) & 11'h7ff;
                        phase = SP_RUN;
                    end
                end
                pending_results.push_back(r);
            end
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(t_result got);
            t_result e;
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending_results.pop_front();
            if (got.edge_valid != e.edge_valid)
                report("edge_valid", int'(got.edge_valid), int'(e.edge_valid));
            if (got.first_vertex != e.first_vertex)
                report("first_vertex", int'(got.first_vertex), int'(e.first_vertex));
            if (got.second_vertex != e.second_vertex)
                report("second_vertex", int'(got.second_vertex), int'(e.second_vertex));
            if (got.first_label != e.first_label)
                report("first_label", int'(got.first_label), int'(e.first_label));
            if (got.second_label != e.second_label)
                report("second_label", int'(got.second_label), int'(e.second_label));
            if (got.component_number != e.component_number)
                report("component_number", int'(got.component_number),
                       int'(e.component_number));
            if (got.component_end != e.component_end)
                report("component_end", int'(got.component_end), int'(e.component_end));
            if (got.component_vertices != e.component_vertices)
                report("component_vertices", int'(got.component_vertices),
                       int'(e.component_vertices));
            if (got.all_done != e.all_done)
                report("all_done", int'(got.all_done), int'(e.all_done));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [1:0]  i_mode = MODE_NONE;
    logic [6:0]  i_owner_vertex = '0;
    logic [6:0]  i_neighbour_vertex = '0;
    logic        i_cfg_we = 0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        o_strobe;
    t_result     got;

    bcf_scoreboard sb;
    int            cycles = 0;
    int            nodes;

    biconnected_component_finder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_owner_vertex(i_owner_vertex),
        .i_neighbour_vertex(i_neighbour_vertex),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_strobe(o_strobe),
        .o_edge_valid(got.edge_valid), .o_first_vertex(got.first_vertex),
        .o_second_vertex(got.second_vertex), .o_first_label(got.first_label),
        .o_second_label(got.second_label), .o_component_number(got.component_number),
        .o_component_end(got.component_end),
        .o_component_vertices(got.component_vertices), .o_all_done(got.all_done)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Check results and guard the run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) sb.check_result(got);
        if (cycles > LIMIT) begin
            $display("biconnected_component_finder test failed");
            $finish;
        end
    end

    // Issue one command transaction after a random gap
    task automatic send(logic [1:0] mode, int owner, int nb, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        repeat (gap) @(negedge i_clk);
        i_start = 1'b1;
        i_mode = mode;
        i_owner_vertex = owner[6:0];
        i_neighbour_vertex = nb[6:0];
        do @(posedge i_clk); while (o_busy);
        sb.note_command(mode, owner[6:0], nb[6:0]);
        @(negedge i_clk);
        i_start = 1'b0;
        i_mode = 2'($urandom_range(0, 3));
        i_owner_vertex = 7'($urandom);
        i_neighbour_vertex = 7'($urandom);
    endtask

    // Hold until every pending result arrived, then let the block settle
    task automatic drain();
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (1000) @(negedge i_clk);
    endtask

    task automatic write_count(int val);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= val[6:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_count(val);
    endtask

    // Load an undirected random graph on vertices 1..nv, with a few odd entries
    task automatic load_graph(int nv, int edges);
        int a, b;
        send(MODE_CLEAR, 0, 0);
        for (int k = 0; k < edges; k++) begin
            a = $urandom_range(1, nv);
            b = $urandom_range(1, nv);
            if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 127);
            send(MODE_APPEND, a, b, $urandom_range(0, 2) == 0);
            send(MODE_APPEND, b, a, $urandom_range(0, 2) == 0);
        end
    endtask

    task automatic fetch_all(int extra);
        while (1) begin
            send(MODE_FETCH, $urandom, $urandom);
            while (sb.pending_results.size() != 0) @(negedge i_clk);
            if (sb.phase == SP_DONE) break;
        end
        repeat (extra) send(MODE_FETCH, 0, 0);
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty graph, a triangle with a tail, bad entries, mode 3
        send(MODE_FETCH, 0, 0);
        write_count(4);
        send(MODE_APPEND, 1, 2); send(MODE_APPEND, 2, 1);
        send(MODE_APPEND, 2, 3); send(MODE_APPEND, 3, 2);
        send(MODE_APPEND, 3, 1); send(MODE_APPEND, 1, 3);
        send(MODE_APPEND, 3, 4); send(MODE_APPEND, 4, 3);
        send(MODE_APPEND, 4, 4); send(MODE_APPEND, 4, 0);
        send(MODE_APPEND, 4, 127); send(MODE_APPEND, 0, 1);
        send(MODE_APPEND, 127, 1); send(MODE_NONE, 127, 127);
        fetch_all(2);
        write_count(0);
        fetch_all(1);
        write_count(127);
        send(MODE_APPEND, 64, 1); send(MODE_APPEND, 1, 64);
        fetch_all(1);

        // Random graphs at several vertex counts
        for (int g = 0; g < 12; g++) begin
            nodes = (g == 5) ? 64 : $urandom_range(2, 10);
            write_count((g == 9) ? 70 : nodes);
            load_graph(nodes, $urandom_range(1, (g == 5) ? nodes : 2 * nodes));
            fetch_all($urandom_range(0, 1));
        end
        // A full-size graph that overfills an owner's list
        write_count(64);
        send(MODE_CLEAR, 0, 0);
        for (int k = 0; k < 66; k++) send(MODE_APPEND, 1, (k % 64) + 1, 1);
        fetch_all(1);

        drain();
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("biconnected_component_finder test passed");
        end else begin
            $display("biconnected_component_finder test failed");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/bcf_pkg.sv
hdl/bcf_engine.sv
hdl/biconnected_component_finder.sv
test/tb_top.sv
